/* rtl/plbu_pkg.sv */
`timescale 1ns / 1ps
// Package for the price level book update block: sizes, item structs, status
// codes and the per-cell control types. No dependencies.
package plbu_pkg;

  localparam int NUM_BOOKS = 16;
  localparam int DEPTH     = 32;

  localparam int NUM_SIDES = NUM_BOOKS * 2;
  localparam int SL_W      = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int PRICE_W = 48;
  localparam int QTY_W   = 48;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_REFUSED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd6;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [3:0]         book_index;
    logic               side_select;
    logic [PRICE_W-1:0] level_price;
    logic [QTY_W-1:0]   level_quantity;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   level_count;
    logic [PRICE_W-1:0] best_price;
    logic [QTY_W-1:0]   best_quantity;
  } out_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  typedef enum logic [1:0] {
    MODE_INS = 2'd0,
    MODE_DEL = 2'd1,
    MODE_UPD = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

  // Item data every cell compares against
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [CNT_W-1:0]   cnt;
  } cell_ctl_t;

  typedef struct packed {
    logic  wr;
    mode_e mode;
  } cell_cmd_t;

endpackage

/* rtl/plbu_cell.sv */
`timescale 1ns / 1ps
// One level slot of the book: holds this level index for every book side and
// computes its next value from its neighbors. Depends on plbu_pkg.
module plbu_cell import plbu_pkg::*; (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [SL_W-1:0] rd_addr_i,
  input  logic [SL_W-1:0] wr_addr_i,
  input  cell_ctl_t       ctl_i,
  input  cell_cmd_t       cmd_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic            left_ahead_i,
  input  level_t          left_data_i,
  input  level_t          right_data_i,
  input  logic            has_right_i,
  output logic            ahead_o,
  output logic            is_pos_o,
  output logic            eq_o,
  output level_t          data_o,
  output level_t          nxt_o
);

  level_t mem_q [NUM_SIDES];
  level_t rd_q;
  logic   valid;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (cmd_i.wr) begin
      mem_q[wr_addr_i] <= nxt_o;
    end
  end

  assign data_o  = rd_q;
  assign valid   = CNT_W'(idx_i) < ctl_i.cnt;
  assign ahead_o = valid && (ctl_i.side ? (rd_q.price < ctl_i.price)
                                        : (rd_q.price > ctl_i.price));
  assign is_pos_o = !ahead_o && left_ahead_i;
  assign eq_o     = is_pos_o && valid && (rd_q.price == ctl_i.price);

  always_comb begin
    nxt_o = rd_q;
    case (cmd_i.mode)
      MODE_INS: begin
        if (is_pos_o) begin
          nxt_o = '{price: ctl_i.price, qty: ctl_i.qty};
        end else if (!ahead_o) begin
          nxt_o = left_data_i;
        end
      end
      MODE_DEL: begin
        // close the gap: everything from the deleted slot on pulls from the right
        if (!ahead_o && has_right_i) begin
          nxt_o = right_data_i;
        end
      end
      MODE_UPD: begin
        if (eq_o) begin
          nxt_o.qty = ctl_i.qty;
        end
      end
      default: nxt_o = rd_q;
    endcase
  end

endmodule

/* rtl/price_level_book_update.sv */
`timescale 1ns / 1ps
// Price level book update: sorted bid and ask sides per instrument book.
// Depends on plbu_pkg and plbu_cell.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one update or clear item
//   (in_item_i). Output channel out_valid_o / out_ready_i returns exactly one
//   result item per input item, in order (out_item_o).
//   When an item is accepted, its level slots are read from each cell's
//   memory at that edge; the compare state then compares all levels in
//   parallel, shifts the chain of cells and loads the output register. A new
//   item is not accepted until the last leaves the compare state, as each
//   needs a registered read of the per-cell memories and a compare-and-shift.
//   The next item is accepted while a result still waits in the output
//   register; if the receiver stalls further, the compare cycle holds until
//   the output register frees up, and input stays blocked meanwhile.
//   Reset clears all level counts, the state machine and the output valid;
//   level memories are not cleared, entries beyond a side's count are never
//   reported.
module price_level_book_update import plbu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  in_item_t  item_q;
  logic      in_acc, exec_go;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic [CNT_W-1:0] cnt_q [NUM_SIDES];
  logic [SL_W-1:0]  sl_in, sl_q;
  logic             book_ok;
  logic [CNT_W-1:0] cnt_rd, cnt_new;

  cell_ctl_t ctl;
  cell_cmd_t cmd;

  logic   [DEPTH-1:0] ahead, is_pos, eq;
  level_t             data [DEPTH];
  level_t             nxt  [DEPTH];

  logic             hit;
  logic [CNT_W-1:0] pos;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign sl_in      = SL_W'({in_item_i.book_index, in_item_i.side_select});
  assign sl_q       = SL_W'({item_q.book_index, item_q.side_select});
  assign book_ok    = 32'(item_q.book_index) < NUM_BOOKS;
  assign cnt_rd     = cnt_q[sl_q];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    if (exec_go) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign ctl = '{side: item_q.side_select, price: item_q.level_price,
                 qty: item_q.level_quantity, cnt: cnt_rd};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plbu_cell u_cell (
      .clk_i        (clk_i),
      .rd_en_i      (in_acc),
      .rd_addr_i    (sl_in),
      .wr_addr_i    (sl_q),
      .ctl_i        (ctl),
      .cmd_i        (cmd),
      .idx_i        (IDX_W'(i)),
      .left_ahead_i ((i == 0) ? 1'b1 : ahead[(i == 0) ? 0 : i-1]),
      .left_data_i  ((i == 0) ? level_t'('0) : data[(i == 0) ? 0 : i-1]),
      .right_data_i (data[(i == DEPTH-1) ? i : i+1]),
      .has_right_i  (i != DEPTH-1),
      .ahead_o      (ahead[i]),
      .is_pos_o     (is_pos[i]),
      .eq_o         (eq[i]),
      .data_o       (data[i]),
      .nxt_o        (nxt[i])
    );
  end

  // one-hot slot flag to index; no flag means every level ranks ahead
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (is_pos[i] ? CNT_W'(i) : '0);
    end
    if (is_pos == '0) begin
      pos = CNT_W'(DEPTH);
    end
  end
  assign hit = |eq;

  always_comb begin
    logic zero_qty;
    logic full;
    zero_qty        = (item_q.level_quantity == '0);
    full            = (cnt_rd >= CNT_W'(DEPTH));
    cmd             = '{wr: 1'b0, mode: MODE_NOP};
    cnt_new         = cnt_rd;
    out_d           = '0;
    out_d.position  = POS_W'(pos);
    if (!book_ok) begin
      out_d.status   = ST_IGNORED;
      out_d.position = '0;
    end else if (item_q.operation == OP_CLEAR) begin
      out_d.status   = ST_CLEARED;
      out_d.position = '0;
      cnt_new        = '0;
    end else if (hit && zero_qty) begin
      out_d.status = ST_DELETED;
      cmd.mode     = MODE_DEL;
      cnt_new      = cnt_rd - CNT_W'(1);
    end else if (hit) begin
      out_d.status = ST_UPDATED;
      cmd.mode     = MODE_UPD;
    end else if (zero_qty) begin
      out_d.status = ST_IGNORED;
    end else if (full && pos == CNT_W'(DEPTH)) begin
      out_d.status = ST_REFUSED;
    end else if (full) begin
      out_d.status = ST_DROPPED;
      cmd.mode     = MODE_INS;
    end else begin
      out_d.status = ST_INSERTED;
      cmd.mode     = MODE_INS;
      cnt_new      = cnt_rd + CNT_W'(1);
    end
    cmd.wr = exec_go && (cmd.mode != MODE_NOP);
    if (book_ok) begin
      out_d.level_count = POS_W'(cnt_new);
      if (cnt_new != '0) begin
        out_d.best_price    = nxt[0].price;
        out_d.best_quantity = nxt[0].qty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SIDES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (exec_go && book_ok) begin
      if (item_q.operation == OP_CLEAR) begin
        cnt_q[{sl_q[SL_W-1:1], 1'b0}] <= '0;
        cnt_q[{sl_q[SL_W-1:1], 1'b1}] <= '0;
      end else begin
        cnt_q[sl_q] <= cnt_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (cnt_rd <= CNT_W'(DEPTH)))
    else $error("side level count above depth");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second item accepted during compare cycle");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_REFUSED) |->
      (out_item_o.level_count == POS_W'(DEPTH)))
    else $error("refused item on a side that is not full");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> exec_go)
    else $error("level write outside the compare cycle");

endmodule

/* test/plbu_checker.sv */
`timescale 1ns / 1ps
// Checker for the price level book update block: watches both channels,
// keeps its own copy of every book side and compares each result item.
// Depends on plbu_pkg.
module plbu_checker import plbu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  level_t    book_lvl [NUM_SIDES][DEPTH];
  int        book_cnt [NUM_SIDES];
  out_item_t expected_q [$];
  int        mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_q.size();

  function automatic bit ahead(logic side, logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    return side ? (a < b) : (a > b);
  endfunction

  function automatic out_item_t apply_update(in_item_t it);
    out_item_t r;
    int sl, cnt, pos;
    sl  = it.book_index * 2 + it.side_select;
    cnt = book_cnt[sl];
    pos = 0;
    r   = '0;
    if (it.operation == OP_CLEAR) begin
      book_cnt[it.book_index*2]   = 0;
      book_cnt[it.book_index*2+1] = 0;
      r.status = ST_CLEARED;
      return r;
    end
    while (pos < cnt && ahead(it.side_select, book_lvl[sl][pos].price, it.level_price))
      pos++;
    if (pos < cnt && book_lvl[sl][pos].price == it.level_price) begin
      if (it.level_quantity == 0) begin
        for (int i = pos; i + 1 < cnt; i++) book_lvl[sl][i] = book_lvl[sl][i+1];
        book_cnt[sl] = cnt - 1;
        r.status = ST_DELETED;
      end else begin
        book_lvl[sl][pos].qty = it.level_quantity;
        r.status = ST_UPDATED;
      end
    end else if (it.level_quantity == 0) begin
      r.status = ST_IGNORED;
    end else if (cnt >= DEPTH && pos >= DEPTH) begin
      r.status = ST_REFUSED;
      pos = DEPTH;
    end else begin
      // shift worse levels down; at full depth the worst one falls off
      for (int i = (cnt >= DEPTH) ? DEPTH - 1 : cnt; i > pos; i--)
        book_lvl[sl][i] = book_lvl[sl][i-1];
      book_lvl[sl][pos] = '{it.level_price, it.level_quantity};
      r.status = (cnt >= DEPTH) ? ST_DROPPED : ST_INSERTED;
      if (cnt < DEPTH) book_cnt[sl] = cnt + 1;
    end
    r.position    = pos[POS_W-1:0];
    r.level_count = book_cnt[sl][POS_W-1:0];
    if (book_cnt[sl] > 0) begin
      r.best_price    = book_lvl[sl][0].price;
      r.best_quantity = book_lvl[sl][0].qty;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      foreach (book_cnt[i]) book_cnt[i] = 0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(apply_update(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_item_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected st=%0d pos=%0d cnt=%0d bp=%h bq=%h, got st=%0d pos=%0d cnt=%0d bp=%h bq=%h",
                       exp_r.status, exp_r.position, exp_r.level_count, exp_r.best_price,
                       exp_r.best_quantity, out_item_i.status, out_item_i.position,
                       out_item_i.level_count, out_item_i.best_price, out_item_i.best_quantity);
          end
        end
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Top of the price level book update test: clock, reset, stimulus and verdict.
// Depends on plbu_pkg, price_level_book_update and plbu_checker.
module tb;
  import plbu_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending;
  bit        hold_off;

  // shadow of price sets per side so that many updates hit present levels
  logic [PRICE_W-1:0] known_px [NUM_SIDES][$];

  price_level_book_update u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_item_i(in_item), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_item_o(out_item)
  );

  plbu_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_item_i(in_item), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_item_i(out_item), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // hold the item until the edge that accepts it; ready is stable at the falling edge
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_level(int book, int side, logic [PRICE_W-1:0] px,
                            logic [QTY_W-1:0] qty, logic op);
    in_item_t it;
    it = '{op, book[3:0], side[0], px, qty};
    send_item(it);
  endtask

  // prices drawn from a small pool so that updates, deletes and full sides occur
  function automatic logic [PRICE_W-1:0] pick_price(int sl);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && known_px[sl].size() > 0)
      return known_px[sl][$urandom_range(0, known_px[sl].size() - 1)];
    if (r == 9) return PRICE_W'({$urandom, $urandom});
    return 48'd1000 + $urandom_range(0, 60);
  endfunction

  // receiver: random stalls, one long hold-off early on
  initial begin
    int rx_cycle;
    out_ready = 1'b0;
    hold_off  = 1'b0;
    rx_cycle  = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_cycle++;
      hold_off = (rx_cycle >= 20) && (rx_cycle < 420);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    end
  end

  initial begin
    int sl, gap, burst;
    logic [QTY_W-1:0] q;
    in_valid = 1'b0;
    in_item  = '0;
    burst    = 0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both operations, each special case
    send_level(0, 0, 48'd500, 48'hFFFF_FFFF_FFFF, OP_UPDATE);
    send_level(0, 0, 48'd500, 48'd7, OP_UPDATE);
    send_level(0, 0, 48'd900, 48'd1, OP_UPDATE);
    send_level(0, 0, 48'd123, 48'd0, OP_UPDATE);
    send_level(0, 0, 48'd500, 48'd0, OP_UPDATE);
    send_level(15, 1, 48'hFFFF_FFFF_FFFF, 48'd3, OP_UPDATE);
    send_level(15, 1, 48'd0, 48'd4, OP_UPDATE);
    send_level(15, 0, 48'd0, 48'd0, OP_UPDATE);
    send_level(15, 1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, OP_CLEAR);
    // fill ask side of book 3, then refuse a worse price and drop with a better one
    for (int i = 0; i < DEPTH; i++) send_level(3, 1, 48'd10 + 2 * i, 48'd5 + i, OP_UPDATE);
    send_level(3, 1, 48'd999, 48'd1, OP_UPDATE);
    send_level(3, 1, 48'd11, 48'd2, OP_UPDATE);
    send_level(3, 1, 48'd1, 48'd2, OP_UPDATE);
    send_level(3, 0, 48'd1, 48'd2, OP_CLEAR);

    // random: mostly updates on a pool of prices, clears now and then
    for (int n = 0; n < 1600; n++) begin
      sl = $urandom_range(0, 3) == 0 ? $urandom_range(0, NUM_SIDES - 1)
                                     : $urandom_range(0, 3);
      if ($urandom_range(0, 79) == 0) begin
        send_level(sl / 2, sl % 2, PRICE_W'({$urandom, $urandom}),
                   QTY_W'({$urandom, $urandom}), OP_CLEAR);
        known_px[sl & ~1].delete();
        known_px[sl | 1].delete();
      end else begin
        in_item_t it;
        q = ($urandom_range(0, 3) == 0) ? 48'd0 :
            ($urandom_range(0, 7) == 0) ? QTY_W'({$urandom, $urandom}) :
                                          QTY_W'($urandom_range(1, 500));
        it = '{OP_UPDATE, sl[4:1], sl[0], pick_price(sl), q};
        if (q != 0) known_px[sl].push_back(it.level_price);
        if (known_px[sl].size() > 64) void'(known_px[sl].pop_front());
        send_item(it);
      end
      if (burst > 0) burst--;
      else begin
        burst = $urandom_range(0, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
